// ===== rtl/mcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coin change solver package
// Widths, codes, table entry and memory request types, and the reset contents
// of the denomination table.
// ----------------------------------------------------------------------------
package mcc_pkg;

   localparam int SUM_W       = 16;
   localparam int MAX_SUM     = 65535;
   localparam int TABLE_DEPTH = MAX_SUM + 1;
   localparam int NUM_COINS   = 16;
   localparam int COIN_W      = 4;
   localparam int CNT_W       = 5;
   localparam int VALUE_W     = 16;
   localparam int FEW_W       = 17;
   localparam int TALLY_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int RESET_COINS = 13;

   localparam logic [FEW_W-1:0]   NO_PATH   = {FEW_W{1'b1}};
   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_SOLVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNREACHABLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER_TARGET = 2'd2;

   typedef struct packed {
      logic [FEW_W-1:0]  fewest;
      logic [COIN_W-1:0] coin;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [SUM_W-1:0] waddr;
      entry_type        wdata;
      logic [SUM_W-1:0] raddr;
   } mem_req_type;

   function automatic logic [VALUE_W-1:0] denom_reset(input logic [COIN_W-1:0] idx);
      logic [VALUE_W-1:0] value;
      unique case (idx)
         4'd0:    value = 16'd441;
         4'd1:    value = 16'd620;
         4'd2:    value = 16'd809;
         4'd3:    value = 16'd1071;
         4'd4:    value = 16'd441;
         4'd5:    value = 16'd777;
         4'd6:    value = 16'd368;
         4'd7:    value = 16'd515;
         4'd8:    value = 16'd672;
         4'd9:    value = 16'd893;
         4'd10:   value = 16'd2148;
         4'd11:   value = 16'd1074;
         4'd12:   value = 16'd537;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mcc_table_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coin change table memory
// One write port and one read port; read data is registered and shows the
// entry as it was before a write at the same edge.
// ----------------------------------------------------------------------------
module mcc_table_ram (
   input  wire logic                 clock,
   input  wire mcc_pkg::mem_req_type mem_req,
   output mcc_pkg::entry_type        mem_rdata
);
   import mcc_pkg::*;

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

   assign mem_rdata = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/mcc_solver_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coin change solve sequencer
// Clears the table, relaxes reachable sums on the coins in use with a one-deep
// write forward, walks back from the remaining sum and sends counts or status.
// ----------------------------------------------------------------------------
module mcc_solver_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_kind,
   input  wire logic [mcc_pkg::SUM_W-1:0]     req_target_points,
   input  wire logic [mcc_pkg::SUM_W-1:0]     req_current_points,
   input  wire logic [mcc_pkg::CNT_W-1:0]     coins_in_use,
   output logic [mcc_pkg::COIN_W-1:0]         coin_sel,
   input  wire logic [mcc_pkg::VALUE_W-1:0]   coin_sel_value,
   output mcc_pkg::mem_req_type               mem_req,
   input  wire mcc_pkg::entry_type            mem_rdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mcc_pkg::COIN_W-1:0]         rsp_result_coin,
   output logic [mcc_pkg::TALLY_W-1:0]        rsp_use_count,
   output logic [mcc_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_last
);
   import mcc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_CLEAR    = 9'b000000010,
      ST_SRC_RD   = 9'b000000100,
      ST_SRC_CHK  = 9'b000001000,
      ST_COIN     = 9'b000010000,
      ST_WALK_RD  = 9'b000100000,
      ST_WALK_CHK = 9'b001000000,
      ST_EMIT     = 9'b010000000,
      ST_STATUS   = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     src_ff, src_in;
   logic [SUM_W-1:0]     point_ff, point_in;
   logic [COIN_W-1:0]    coin_ff, coin_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [FEW_W-1:0]     here_ff, here_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SUM_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [COIN_W-1:0]    pend_coin_ff, pend_coin_in;
   logic [SUM_W-1:0]     rd_addr_ff;
   logic                 wr_valid_ff;
   logic [SUM_W-1:0]     wr_addr_ff;
   entry_type            wr_data_ff;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [TALLY_W-1:0]   tally_ff [NUM_COINS];
   logic [TALLY_W-1:0]   tally_in [NUM_COINS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COIN_W-1:0]    rsp_coin_ff, rsp_coin_in;
   logic [TALLY_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   entry_type            rd_fwd;
   logic                 out_free;
   logic                 coin_is_last;
   logic [SUM_W-1:0]     span;
   logic [FEW_W-1:0]     cand;
   logic [SUM_W-1:0]     walk_next;

   assign rd_fwd = (wr_valid_ff && (wr_addr_ff == rd_addr_ff)) ? wr_data_ff : mem_rdata;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign coin_is_last = (CNT_W'(coin_ff) + CNT_W'(1)) == n_ff;
   assign span         = rem_ff - src_ff;
   assign cand         = here_ff + FEW_W'(1);
   assign walk_next    = point_ff - coin_sel_value;
   assign coin_sel     = (state_ff == ST_WALK_CHK) ? rd_fwd.coin : coin_ff;
   assign req_stall    = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      src_in        = src_ff;
      point_in      = point_ff;
      coin_in       = coin_ff;
      n_in          = n_ff;
      here_in       = here_ff;
      status_in     = status_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_coin_in  = pend_coin_ff;
      tally_in      = tally_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_coin_in   = rsp_coin_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_req       = '0;
      mem_req.raddr = src_ff;

      if (pend_valid_ff && (cand < rd_fwd.fewest)) begin
         mem_req.we           = 1'b1;
         mem_req.waddr        = pend_addr_ff;
         mem_req.wdata.fewest = cand;
         mem_req.wdata.coin   = pend_coin_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_kind == KIND_SOLVE)) begin
               if (req_current_points > req_target_points) begin
                  status_in = STATUS_OVER_TARGET;
                  state_in  = ST_STATUS;
               end else begin
                  rem_in   = req_target_points - req_current_points;
                  n_in     = (coins_in_use > CNT_W'(NUM_COINS)) ? CNT_W'(NUM_COINS)
                                                                : coins_in_use;
                  src_in   = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            mem_req.we           = 1'b1;
            mem_req.waddr        = src_ff;
            mem_req.wdata.fewest = (src_ff == '0) ? '0 : NO_PATH;
            mem_req.wdata.coin   = '0;
            if (src_ff == rem_ff) begin
               src_in   = '0;
               state_in = ST_SRC_RD;
            end else begin
               src_in = src_ff + SUM_W'(1);
            end
         end
         ST_SRC_RD: begin
            mem_req.raddr = src_ff;
            state_in      = ST_SRC_CHK;
         end
         ST_SRC_CHK: begin
            if (src_ff == rem_ff) begin
               if (rd_fwd.fewest == NO_PATH) begin
                  status_in = STATUS_UNREACHABLE;
                  state_in  = ST_STATUS;
               end else begin
                  point_in = rem_ff;
                  for (int k = 0; k < NUM_COINS; k++) begin
                     tally_in[k] = '0;
                  end
                  state_in = ST_WALK_RD;
               end
            end else if ((rd_fwd.fewest == NO_PATH) || (n_ff == '0)) begin
               src_in        = src_ff + SUM_W'(1);
               mem_req.raddr = src_ff + SUM_W'(1);
            end else begin
               here_in  = rd_fwd.fewest;
               coin_in  = '0;
               state_in = ST_COIN;
            end
         end
         ST_COIN: begin
            if ((coin_sel_value != '0) && (coin_sel_value <= span)) begin
               mem_req.raddr = src_ff + coin_sel_value;
               pend_valid_in = 1'b1;
               pend_addr_in  = src_ff + coin_sel_value;
               pend_coin_in  = coin_ff;
            end
            if (coin_is_last) begin
               src_in   = src_ff + SUM_W'(1);
               state_in = ST_SRC_RD;
            end else begin
               coin_in = coin_ff + COIN_W'(1);
            end
         end
         ST_WALK_RD: begin
            coin_in = '0;
            if (point_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               mem_req.raddr = point_ff;
               state_in      = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            coin_in = '0;
            if ((coin_sel_value == '0) || (coin_sel_value > point_ff)) begin
               state_in = ST_EMIT;
            end else begin
               if (tally_ff[coin_sel] != TALLY_MAX) begin
                  tally_in[coin_sel] = tally_ff[coin_sel] + TALLY_W'(1);
               end
               point_in      = walk_next;
               mem_req.raddr = walk_next;
               if (walk_next == '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               if (n_ff == '0) begin
                  rsp_coin_in  = '0;
                  rsp_count_in = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_coin_in  = coin_ff;
                  rsp_count_in = tally_ff[coin_ff];
                  rsp_last_in  = coin_is_last;
                  if (coin_is_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     coin_in = coin_ff + COIN_W'(1);
                  end
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_coin_in   = '0;
               rsp_count_in  = '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         wr_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         wr_valid_ff   <= mem_req.we;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      src_ff        <= src_in;
      point_ff      <= point_in;
      coin_ff       <= coin_in;
      n_ff          <= n_in;
      here_ff       <= here_in;
      status_ff     <= status_in;
      pend_addr_ff  <= pend_addr_in;
      pend_coin_ff  <= pend_coin_in;
      rd_addr_ff    <= mem_req.raddr;
      wr_addr_ff    <= mem_req.waddr;
      wr_data_ff    <= mem_req.wdata;
      tally_ff      <= tally_in;
      rsp_coin_ff   <= rsp_coin_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_coin = rsp_coin_ff;
   assign rsp_use_count   = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   // The table is only written while a solve is running.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_req.we)
      else $error("table write while idle");

   // A source sum is only expanded when it is reachable.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COIN) |-> (here_ff != NO_PATH))
      else $error("unreachable source expanded");

   // No write ever lands beyond the remaining sum.
   assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (mem_req.waddr <= rem_ff))
      else $error("table write beyond remaining sum");

   // The walk back strictly decreases the point.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK_CHK) && ($past(state_ff) == ST_WALK_CHK))
         |-> (point_ff < $past(point_ff)))
      else $error("walk back did not advance");

endmodule
`default_nettype wire

// ===== rtl/min_coin_change_solver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum coin change solver
// A req_ beat with kind 0 writes one denomination slot and gives no result.
// A req_ beat with kind 1 solves for target minus current points with the
// fewest coins drawn from the first coins_in_use slots, then sends one rsp_
// beat per slot in use (up to 16, last set on the final one), one beat if
// none is in use, or a single status beat when the current sum is above the
// target or the sum is unreachable. The csr_ channel writes coins_in_use;
// csr_ready is always high. A solve over remaining sum R first clears the
// table up to R, then steps through the sums below R, skipping unreachable
// ones and trying every coin in use on each reachable one, all through the
// single table read port, then walks back from R and sends the result beats.
// The next request is taken when the last result sits in the output
// register.
// Reset restores coins_in_use to 13 and the denomination slots to their
// default values; the table itself is not cleared. A stalled rsp_ beat is
// held, and the sequencer waits with the next beat until it is taken.
// ----------------------------------------------------------------------------
module min_coin_change_solver_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_kind,
   input  wire logic [mcc_pkg::COIN_W-1:0]  req_coin_index,
   input  wire logic [mcc_pkg::VALUE_W-1:0] req_coin_value,
   input  wire logic [mcc_pkg::SUM_W-1:0]   req_target_points,
   input  wire logic [mcc_pkg::SUM_W-1:0]   req_current_points,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [mcc_pkg::COIN_W-1:0]       rsp_result_coin,
   output logic [mcc_pkg::TALLY_W-1:0]      rsp_use_count,
   output logic [mcc_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_last,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [mcc_pkg::CNT_W-1:0]   csr_data
);
   import mcc_pkg::*;

   logic [CNT_W-1:0]   coins_in_use_ff;
   logic [VALUE_W-1:0] denom_ff [NUM_COINS];
   logic [COIN_W-1:0]  coin_sel;
   logic [VALUE_W-1:0] coin_sel_value;
   mem_req_type        mem_req;
   entry_type          mem_rdata;
   logic               denom_write;

   assign csr_ready      = 1'b1;
   assign denom_write    = req_valid && !req_stall && (req_kind == KIND_WRITE);
   assign coin_sel_value = denom_ff[coin_sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         coins_in_use_ff <= CNT_W'(RESET_COINS);
         for (int k = 0; k < NUM_COINS; k++) begin
            denom_ff[k] <= denom_reset(COIN_W'(k));
         end
      end else begin
         if (csr_valid && csr_ready) begin
            coins_in_use_ff <= csr_data;
         end
         if (denom_write) begin
            denom_ff[req_coin_index] <= req_coin_value;
         end
      end
   end

   mcc_solver_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_target_points  (req_target_points),
      .req_current_points (req_current_points),
      .coins_in_use       (coins_in_use_ff),
      .coin_sel           (coin_sel),
      .coin_sel_value     (coin_sel_value),
      .mem_req            (mem_req),
      .mem_rdata          (mem_rdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_coin    (rsp_result_coin),
      .rsp_use_count      (rsp_use_count),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   mcc_table_ram u_table (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

endmodule
`default_nettype wire

// ===== sim/min_coin_change_solver_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum coin change solver testbench
// Drives denomination writes and solve requests into the solver, keeps its own
// copy of the denomination table and coin count register, and works out the
// fewest-coins split for every accepted solve. Each result beat is checked
// field by field against the oldest planned beat. Directed tests cover the
// reset table, zero and largest sums, over-target and unreachable requests,
// no coins and saturated coin counts; random tests mix writes and solves with
// and without random gaps and stalls; a directed test adds one long output hold-off.
// ----------------------------------------------------------------------------
module min_coin_change_solver_top_test;
   import mcc_pkg::*;

   localparam int          HOLD_CYCLES = 400;
   localparam int          SETTLE_CYCLES = 40;
   localparam longint      TIMEOUT_NS = 8_000_000;
   localparam int unsigned UNSOLVED = 32'hFFFF_FFFF;
   localparam logic [VALUE_W-1:0] START_VALUES [0:12] = '{
      16'd441, 16'd620, 16'd809, 16'd1071, 16'd441, 16'd777, 16'd368,
      16'd515, 16'd672, 16'd893, 16'd2148, 16'd1074, 16'd537
   };

   typedef struct packed {
      logic [COIN_W-1:0]   coin;
      logic [TALLY_W-1:0]  count;
      logic [STATUS_W-1:0] status;
      logic                last;
   } coin_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = KIND_WRITE;
   logic [COIN_W-1:0]   req_coin_index = '0;
   logic [VALUE_W-1:0]  req_coin_value = '0;
   logic [SUM_W-1:0]    req_target_points = '0;
   logic [SUM_W-1:0]    req_current_points = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COIN_W-1:0]   rsp_result_coin;
   logic [TALLY_W-1:0]  rsp_use_count;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_data = '0;

   logic req_idle_on = 1'b1;
   logic rsp_idle_on = 1'b1;
   logic hold_on = 1'b0;

   logic [VALUE_W-1:0] denoms [NUM_COINS];
   logic [CNT_W-1:0]   coin_limit;
   int unsigned        coins_for_sum [0:MAX_SUM];
   logic [COIN_W-1:0]  last_coin_for_sum [0:MAX_SUM];
   coin_beat_type      planned_beats [$];

   int error_count = 0;
   int solves_seen = 0;
   int writes_seen = 0;
   int limit_writes = 0;
   int beats_checked = 0;

   min_coin_change_solver_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_coin_index     (req_coin_index),
      .req_coin_value     (req_coin_value),
      .req_target_points  (req_target_points),
      .req_current_points (req_current_points),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_coin    (rsp_result_coin),
      .rsp_use_count      (rsp_use_count),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= hold_on || (rsp_idle_on && $urandom_range(99) < 34);
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   function automatic void push_beat(input logic [COIN_W-1:0] coin,
                                     input logic [TALLY_W-1:0] count,
                                     input logic [STATUS_W-1:0] status,
                                     input logic last);
      coin_beat_type beat;
      beat.coin = coin;
      beat.count = count;
      beat.status = status;
      beat.last = last;
      planned_beats.push_back(beat);
   endfunction

   function automatic void plan_coin_counts(input logic [SUM_W-1:0] target,
                                            input logic [SUM_W-1:0] current);
      int unsigned        rem;
      int unsigned        n;
      int unsigned        v;
      int unsigned        point;
      logic [COIN_W-1:0]  c;
      logic [TALLY_W-1:0] tally [NUM_COINS];
      if (current > target) begin
         push_beat('0, '0, STATUS_OVER_TARGET, 1'b1);
         return;
      end
      rem = target - current;
      n = (coin_limit > NUM_COINS) ? NUM_COINS : coin_limit;
      for (int unsigned i = 0; i <= rem; i++) begin
         coins_for_sum[i] = UNSOLVED;
         last_coin_for_sum[i] = '0;
      end
      coins_for_sum[0] = 0;
      for (int unsigned i = 0; i <= rem; i++) begin
         if (coins_for_sum[i] == UNSOLVED) continue;
         for (int unsigned j = 0; j < n; j++) begin
            v = denoms[j];
            if (v > rem - i) continue;
            if (coins_for_sum[i] + 1 < coins_for_sum[i + v]) begin
               coins_for_sum[i + v] = coins_for_sum[i] + 1;
               last_coin_for_sum[i + v] = j[COIN_W-1:0];
            end
         end
      end
      if (coins_for_sum[rem] == UNSOLVED) begin
         push_beat('0, '0, STATUS_UNREACHABLE, 1'b1);
         return;
      end
      foreach (tally[j]) tally[j] = '0;
      point = rem;
      while (point != 0) begin
         c = last_coin_for_sum[point];
         v = denoms[c];
         if (v == 0 || v > point) break;
         if (tally[c] != TALLY_MAX) tally[c]++;
         point -= v;
      end
      if (n == 0) begin
         push_beat('0, '0, STATUS_OK, 1'b1);
         return;
      end
      for (int unsigned j = 0; j < n; j++) begin
         push_beat(j[COIN_W-1:0], tally[j], STATUS_OK, j + 1 == n);
      end
   endfunction

   task automatic check_beat();
      coin_beat_type want;
      beats_checked++;
      if (planned_beats.size() == 0) begin
         report_error($sformatf("result beat with nothing outstanding: coin %0d count %0d",
                                rsp_result_coin, rsp_use_count));
         return;
      end
      want = planned_beats.pop_front();
      if (rsp_result_coin !== want.coin)
         report_error($sformatf("result_coin got %0d expected %0d", rsp_result_coin,
                                want.coin));
      if (rsp_use_count !== want.count)
         report_error($sformatf("use_count of coin %0d got %0d expected %0d", want.coin,
                                rsp_use_count, want.count));
      if (rsp_status !== want.status)
         report_error($sformatf("status got %0d expected %0d", rsp_status, want.status));
      if (rsp_last !== want.last)
         report_error($sformatf("last got %0b expected %0b", rsp_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         coin_limit = CNT_W'(RESET_COINS);
         foreach (denoms[i]) denoms[i] = (i < 13) ? START_VALUES[i] : '0;
      end else begin
         if (csr_valid && csr_ready) begin
            coin_limit = csr_data;
            limit_writes++;
         end
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_WRITE) begin
               denoms[req_coin_index] = req_coin_value;
               writes_seen++;
            end else begin
               plan_coin_counts(req_target_points, req_current_points);
               solves_seen++;
            end
         end
         if (rsp_valid && !rsp_stall) check_beat();
      end
   end

   task automatic send_request(input logic kind, input logic [COIN_W-1:0] index,
                               input logic [VALUE_W-1:0] value,
                               input logic [SUM_W-1:0] target,
                               input logic [SUM_W-1:0] current);
      if (req_idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 34);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_coin_index <= index;
      req_coin_value <= value;
      req_target_points <= target;
      req_current_points <= current;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_write(input logic [COIN_W-1:0] index, input logic [VALUE_W-1:0] value);
      send_request(KIND_WRITE, index, value, SUM_W'($urandom), SUM_W'($urandom));
   endtask

   task automatic send_solve(input logic [SUM_W-1:0] target, input logic [SUM_W-1:0] current);
      send_request(KIND_SOLVE, COIN_W'($urandom), VALUE_W'($urandom), target, current);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while ((planned_beats.size() != 0) || req_stall) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coin_limit(input logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_item();
      int unsigned        pick;
      int unsigned        rem;
      logic [SUM_W-1:0]   target;
      logic [SUM_W-1:0]   current;
      logic [VALUE_W-1:0] value;
      pick = $urandom_range(99);
      if (pick < 35) begin
         case ($urandom_range(5))
            0:       value = '0;
            1:       value = VALUE_W'($urandom);
            default: value = VALUE_W'($urandom_range(1, 40));
         endcase
         send_write(COIN_W'($urandom), value);
      end else if (pick < 90) begin
         target = SUM_W'($urandom);
         rem = $urandom_range(0, 120);
         if (rem > target) rem = target;
         send_solve(target, target - SUM_W'(rem));
      end else begin
         current = SUM_W'($urandom_range(1, 65535));
         target = SUM_W'($urandom_range(0, current - 1));
         send_solve(target, current);
      end
   endtask

   task automatic test_default_table();
      send_solve(16'd0, 16'd0);
      send_solve(16'd441, 16'd0);
      send_solve(16'd1500, 16'd59);
      send_solve(16'd0, 16'd65535);
      send_solve(16'd65535, 16'd65535);
      send_solve(16'd100, 16'd1);
      wait_idle();
   endtask

   task automatic test_custom_coins();
      write_coin_limit(CNT_W'(16));
      send_write(4'd13, 16'd0);
      send_write(4'd14, 16'd7);
      send_write(4'd15, 16'hFFFF);
      send_solve(16'd21, 16'd0);
      send_solve(16'd65535, 16'd65000);
      wait_idle();
      write_coin_limit(CNT_W'(31));
      send_solve(16'd14, 16'd0);
      send_solve(16'd1200, 16'd1000);
      wait_idle();
   endtask

   task automatic test_no_coins();
      write_coin_limit('0);
      send_solve(16'd500, 16'd500);
      send_solve(16'd9, 16'd0);
      wait_idle();
   endtask

   task automatic test_largest_sum();
      write_coin_limit(CNT_W'(1));
      send_write(4'd0, 16'd1);
      send_solve(16'd65535, 16'd0);
      wait_idle();
   endtask

   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_coin_limit(CNT_W'(16));
      repeat (20) send_random_item();
      wait_idle();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      write_coin_limit(CNT_W'(16));
      fork
         begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
         begin
            send_solve(16'd0, 16'd0);
            send_solve(16'd12, 16'd0);
            send_solve(16'd40000, 16'd40000);
            send_solve(16'd30, 16'd7);
            send_write(4'd3, 16'd2);
            send_solve(16'd9, 16'd0);
         end
      join
      wait_idle();
   endtask

   task automatic test_random_mix();
      int unsigned pick;
      repeat (4) begin
         pick = $urandom_range(99);
         if (pick < 10) write_coin_limit('0);
         else if (pick < 20) write_coin_limit(CNT_W'($urandom_range(17, 31)));
         else write_coin_limit(CNT_W'($urandom_range(1, 16)));
         repeat (16) send_random_item();
         wait_idle();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_table();
      test_custom_coins();
      test_no_coins();
      test_largest_sum();
      test_back_to_back();
      test_output_backpressure();
      test_random_mix();
      wait_idle();
      $display("Covered %0d solves, %0d denomination writes, %0d coin count writes,",
               solves_seen, writes_seen, limit_writes);
      $display("%0d result beats checked, sums up to 65535 and a %0d-cycle output hold-off.",
               beats_checked, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout after %0d ns with %0d result beats outstanding.", TIMEOUT_NS,
               planned_beats.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mcc_pkg.sv
rtl/mcc_table_ram.sv
rtl/mcc_solver_ctrl.sv
rtl/min_coin_change_solver_top.sv
sim/min_coin_change_solver_top_test.sv
